// ===== hdl/gm3_pkg.sv =====
// Shared constants, types and helpers for the 3x3 gray morphology block.
package gm3_pkg;

  localparam int MAX_LINE  = 1024;
  localparam int MAX_LINES = 1024;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int LEN_W  = $clog2(MAX_LINE + 1);
  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  // output lags input by up to two lines, so the input line runs a bit past the count
  localparam int LINE_W = $clog2(MAX_LINES + 3);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] LINE_LENGTH_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] LINE_COUNT_RESET  = CFG_W'(1024);

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  localparam logic MODE_EROSION  = 1'b0;
  localparam logic MODE_DILATION = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MIN = '0;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  // one classified transaction handed from the front to the back
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             emit;
    logic             last;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
  } job_t;

  function automatic logic [LEN_W-1:0] len_extent(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return LEN_W'(1);
    end else if (int'(v) > MAX_LINE) begin
      return LEN_W'(MAX_LINE);
    end else begin
      return LEN_W'(v);
    end
  endfunction

  function automatic logic [CNT_W-1:0] cnt_extent(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (int'(v) > MAX_LINES) begin
      return CNT_W'(MAX_LINES);
    end else begin
      return CNT_W'(v);
    end
  endfunction

  // minimum for erosion, maximum for dilation
  function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y,
                                            input logic             m);
    if (m == MODE_DILATION) begin
      return (x > y) ? x : y;
    end else begin
      return (x < y) ? x : y;
    end
  endfunction

endpackage

// ===== hdl/gm3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gm3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gm3_front.sv =====
// Front end: accepts transactions, tracks input and output positions, classifies each item.
module gm3_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      func,
  input  logic [gm3_pkg::PIX_W-1:0] pixel_in,
  input  logic [gm3_pkg::LEN_W-1:0] len,
  input  logic [gm3_pkg::CNT_W-1:0] cnt,
  input  logic                      q_full,
  output logic                      push,
  output gm3_pkg::job_t             job
);
  import gm3_pkg::*;

  logic [COL_W-1:0]  in_column;
  logic [COL_W-1:0]  out_column;
  logic [LINE_W-1:0] in_line;
  logic [LINE_W-1:0] out_line;

  logic [COL_W-1:0]  ic_w;
  logic [COL_W-1:0]  oc_w;
  logic [LINE_W-1:0] il_w;
  logic [LINE_W-1:0] ol_w;
  logic [LEN_W-1:0]  ic_inc;
  logic [LEN_W-1:0]  oc_inc;
  logic [LINE_W-1:0] cnt_l;
  logic              accept;
  logic              done;
  logic              ignore;
  logic              emit;
  logic              last;

  always_comb begin
    cnt_l = LINE_W'(cnt);

    // wrap positions that sit at or beyond the current line length
    if (LEN_W'(in_column) >= len) begin
      ic_w = '0;
      il_w = in_line + LINE_W'(1);
    end else begin
      ic_w = in_column;
      il_w = in_line;
    end
    if (LEN_W'(out_column) >= len) begin
      oc_w = '0;
      ol_w = out_line + LINE_W'(1);
    end else begin
      oc_w = out_column;
      ol_w = out_line;
    end

    ic_inc = LEN_W'(ic_w) + LEN_W'(1);
    oc_inc = LEN_W'(oc_w) + LEN_W'(1);

    done   = il_w >= cnt_l;
    ignore = (func == FUNC_FLUSH) && !done;

    // input at least one line plus one pixel ahead of the output
    emit = ({1'b0, il_w} >= ({1'b0, ol_w} + (LINE_W + 1)'(2)))
        || ((il_w == ol_w + LINE_W'(1)) && (ic_w > oc_w));
    last = (ol_w >= cnt_l) || ((ol_w + LINE_W'(1) == cnt_l) && (oc_inc == len));

    in_ready = !q_full;
    accept   = in_valid && in_ready;
    push     = accept && !ignore;

    job.col       = ic_w;
    job.pix       = done ? PIX_MIN : pixel_in;
    job.emit      = emit;
    job.last      = emit && last;
    job.row_ok[0] = ol_w != '0;
    job.row_ok[1] = ol_w < cnt_l;
    job.row_ok[2] = (ol_w + LINE_W'(1)) < cnt_l;
    job.col_ok[0] = oc_w != '0;
    job.col_ok[1] = LEN_W'(oc_w) < len;
    job.col_ok[2] = oc_inc < len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_line    <= '0;
      out_column <= '0;
      out_line   <= '0;
    end else if (accept) begin
      if (ignore) begin
        // hold position, keep only the wrap
        in_column  <= ic_w;
        in_line    <= il_w;
        out_column <= oc_w;
        out_line   <= ol_w;
      end else if (emit && last) begin
        in_column  <= '0;
        in_line    <= '0;
        out_column <= '0;
        out_line   <= '0;
      end else begin
        if (ic_inc == len) begin
          in_column <= '0;
          in_line   <= il_w + LINE_W'(1);
        end else begin
          in_column <= COL_W'(ic_inc);
          in_line   <= il_w;
        end
        if (emit && (oc_inc == len)) begin
          out_column <= '0;
          out_line   <= ol_w + LINE_W'(1);
        end else if (emit) begin
          out_column <= COL_W'(oc_inc);
          out_line   <= ol_w;
        end else begin
          out_column <= oc_w;
          out_line   <= ol_w;
        end
      end
    end
  end

endmodule

// ===== hdl/gm3_queue.sv =====
// Short job queue between the front end and the back end.
module gm3_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gm3_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output gm3_pkg::job_t head
);
  import gm3_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = count == Q_CNT_W'(Q_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hdl/gm3_back.sv =====
// Back end: line stores, 3x3 window, masked min/max and the output register.
module gm3_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mode,
  input  logic                      q_valid,
  input  gm3_pkg::job_t             q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gm3_pkg::PIX_W-1:0] pixel_out,
  output logic                      frame_end
);
  import gm3_pkg::*;

  job_t               s1_job;
  logic               s1_valid;
  logic               s1_fire;
  logic               out_free;
  logic               fwd;
  logic [2*PIX_W-1:0] fwd_data;
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] col_data;
  logic [2*PIX_W-1:0] wr_data;
  logic [PIX_W-1:0]   a;
  logic [PIX_W-1:0]   b;
  logic [PIX_W-1:0]   pad;
  logic [PIX_W-1:0]   best;
  logic [PIX_W-1:0]   win      [9];
  logic [PIX_W-1:0]   win_next [9];
  logic [PIX_W-1:0]   masked   [9];
  logic [PIX_W-1:0]   row_best [3];

  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && (!s1_job.emit || out_free);
  assign q_pop    = q_valid && (!s1_valid || s1_fire);

  // older line in the upper byte, newer line in the lower byte
  gm3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_LINE)
  ) u_lines (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_job.col),
    .wdata (wr_data),
    .re    (q_pop),
    .raddr (q_head.col),
    .rdata (rd_data)
  );

  always_comb begin
    // take the column just written when the next job reads the same address
    col_data = fwd ? fwd_data : rd_data;
    a        = col_data[2*PIX_W-1:PIX_W];
    b        = col_data[PIX_W-1:0];
    wr_data  = {b, s1_job.pix};

    for (int i = 0; i < 3; i++) begin
      win_next[i*3]     = win[i*3+1];
      win_next[i*3 + 1] = win[i*3+2];
    end
    win_next[2] = a;
    win_next[5] = b;
    win_next[8] = s1_job.pix;

    pad = (mode == MODE_DILATION) ? PIX_MIN : PIX_MAX;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        masked[i*3 + j] = (s1_job.row_ok[i] && s1_job.col_ok[j]) ? win_next[i*3 + j] : pad;
      end
    end
    for (int i = 0; i < 3; i++) begin
      row_best[i] = pick(pick(masked[i*3], masked[i*3 + 1], mode), masked[i*3 + 2], mode);
    end
    best = pick(pick(row_best[0], row_best[1], mode), row_best[2], mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd       <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
        fwd      <= s1_fire && (s1_job.col == q_head.col);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
        fwd      <= 1'b0;
      end

      if (s1_fire) begin
        for (int k = 0; k < 9; k++) begin
          win[k] <= s1_job.last ? PIX_MIN : win_next[k];
        end
      end

      if (s1_fire && s1_job.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_job   <= q_head;
      fwd_data <= wr_data;
    end
    if (s1_fire && s1_job.emit) begin
      pixel_out <= best;
      frame_end <= s1_job.last;
    end
  end

endmodule

// ===== hdl/gray_morphology_3x3_unit.sv =====
// Throughput: one transaction per cycle in both directions when out_ready stays high.
// Output path: the input transaction that completes a window (one line plus one pixel later)
// is held in the job queue, then read with its column from the line store read register,
// and the result of that window then enters the output register.
// Reset: clears positions, window, queue and output; registers go to 1024, 1024, erosion.
// Line stores are not cleared; no clearing pass, input is taken from the first cycle.
module gray_morphology_3x3_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gm3_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [gm3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [gm3_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gm3_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_end
);
  import gm3_pkg::*;

  logic [CFG_W-1:0] line_length;
  logic [CFG_W-1:0] line_count;
  logic             mode;
  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] cnt;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  job_t             push_job;
  job_t             q_head;

  assign len = len_extent(line_length);
  assign cnt = cnt_extent(line_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LINE_LENGTH_RESET;
      line_count  <= LINE_COUNT_RESET;
      mode        <= MODE_EROSION;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LINE_LENGTH: line_length <= cfg_data;
        REG_LINE_COUNT:  line_count  <= cfg_data;
        REG_MODE:        mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gm3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .pixel_in (pixel_in),
    .len      (len),
    .cnt      (cnt),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  gm3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  gm3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !q_valid && !out_valid)
    else $error("queue or output not empty after reset");

endmodule
